// ===== sv/rat_pkg.sv =====
// shared types and constants of the register allocation table
package rat_pkg;

    localparam logic [3:0] ACT_ALLOC   = 4'd0;
    localparam logic [3:0] ACT_FORCE   = 4'd1;
    localparam logic [3:0] ACT_REALLOC = 4'd2;
    localparam logic [3:0] ACT_RESOLVE = 4'd3;
    localparam logic [3:0] ACT_FREE    = 4'd4;
    localparam logic [3:0] ACT_USEDBY  = 4'd5;
    localparam logic [3:0] ACT_UNLOCK  = 4'd6;
    localparam logic [3:0] ACT_EVAC    = 4'd7;
    localparam logic [3:0] ACT_RESTORE = 4'd8;

    localparam logic [1:0] CFG_CALLER_ORDER = 2'd0;
    localparam logic [1:0] CFG_CALLER_COUNT = 2'd1;
    localparam logic [1:0] CFG_CALLEE_ORDER = 2'd2;
    localparam logic [1:0] CFG_CALLEE_COUNT = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [4:0]  REG_NONE   = 5'h1F;
    localparam logic [16:0] OWNER_NONE = 17'h1FFFF;
    localparam logic [4:0]  LIST_MAX   = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_FIND,
        S_REWIND,
        S_MOVE,
        S_SCAN,
        S_EXEC,
        S_EVAC,
        S_EVAC_END,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ALLOC,
        DP_FIND,
        DP_REWIND,
        DP_MOVE,
        DP_SCAN,
        DP_EXEC,
        DP_EVAC,
        DP_EMIT_LAST,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic caller_end;
        logic scan_end;
        logic hit;
        logic evac_hold;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

// ===== sv/rat_in_if.sv =====
// input channel of the register allocation table
interface rat_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        action;
    logic [15:0]       virtual_id;
    logic [3:0]        real_reg;
    logic [3:0]        entry_caller_index;
    logic signed [4:0] entry_callee_index;

    modport source (
        output valid, action, virtual_id, real_reg, entry_caller_index,
               entry_callee_index,
        input  ready
    );
    modport sink (
        input  valid, action, virtual_id, real_reg, entry_caller_index,
               entry_callee_index,
        output ready
    );
endinterface

// ===== sv/rat_out_if.sv =====
// result channel of the register allocation table
interface rat_out_if;
    logic               valid;
    logic               ready;
    logic signed [4:0]  reg_result;
    logic signed [16:0] owner;
    logic [3:0]         evac_caller_index;
    logic signed [4:0]  evac_callee_index;
    logic               last;

    modport source (
        output valid, reg_result, owner, evac_caller_index, evac_callee_index, last,
        input  ready
    );
    modport sink (
        input  valid, reg_result, owner, evac_caller_index, evac_callee_index, last,
        output ready
    );
endinterface

// ===== sv/rat_ctrl.sv =====
// sequencing state machine of the register allocation table
module rat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [3:0]       i_in_action,
    output logic             o_in_ready,
    input  rat_pkg::t_status i_status,
    output rat_pkg::t_cmd    o_cmd
);

    rat_pkg::t_state r_state;
    rat_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.op   = rat_pkg::DP_NOP;
        case (r_state)
            rat_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_action)
                        rat_pkg::ACT_ALLOC:   n_state = rat_pkg::S_ALLOC;
                        rat_pkg::ACT_REALLOC: n_state = rat_pkg::S_FIND;
                        rat_pkg::ACT_RESOLVE,
                        rat_pkg::ACT_FREE:    n_state = rat_pkg::S_SCAN;
                        rat_pkg::ACT_FORCE,
                        rat_pkg::ACT_UNLOCK,
                        rat_pkg::ACT_RESTORE: n_state = rat_pkg::S_EXEC;
                        rat_pkg::ACT_EVAC:    n_state = rat_pkg::S_EVAC;
                        default:              n_state = rat_pkg::S_EMIT;
                    endcase
                end
            end
            rat_pkg::S_ALLOC: begin
                o_cmd.op = rat_pkg::DP_ALLOC;
                if (i_status.caller_end || i_status.hit) begin
                    n_state = rat_pkg::S_EMIT;
                end
            end
            rat_pkg::S_FIND: begin
                o_cmd.op = rat_pkg::DP_FIND;
                if (i_status.caller_end || i_status.hit) begin
                    n_state = rat_pkg::S_REWIND;
                end
            end
            rat_pkg::S_REWIND: begin
                o_cmd.op = rat_pkg::DP_REWIND;
                n_state  = rat_pkg::S_MOVE;
            end
            rat_pkg::S_MOVE: begin
                o_cmd.op = rat_pkg::DP_MOVE;
                if (i_status.caller_end || i_status.hit) begin
                    n_state = rat_pkg::S_EMIT;
                end
            end
            rat_pkg::S_SCAN: begin
                o_cmd.op = rat_pkg::DP_SCAN;
                if (i_status.scan_end || i_status.hit) begin
                    n_state = rat_pkg::S_EMIT;
                end
            end
            rat_pkg::S_EXEC: begin
                o_cmd.op = rat_pkg::DP_EXEC;
                n_state  = rat_pkg::S_EMIT;
            end
            rat_pkg::S_EVAC: begin
                if (i_status.caller_end) begin
                    n_state = rat_pkg::S_EVAC_END;
                end else if (!i_status.evac_hold) begin
                    o_cmd.op = rat_pkg::DP_EVAC;
                end
            end
            rat_pkg::S_EVAC_END: begin
                if (!i_status.pend_valid) begin
                    n_state = rat_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.op = rat_pkg::DP_EMIT_LAST;
                    n_state  = rat_pkg::S_IDLE;
                end
            end
            rat_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = rat_pkg::DP_EMIT;
                    n_state  = rat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rat_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/rat_datapath.sv =====
// owner table, order lists, walk pointers and result register
module rat_datapath #(
    parameter int REG_COUNT  = 16,
    parameter int VIRT_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rat_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rat_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [3:0]                       i_action,
    input  logic [15:0]                      i_virtual_id,
    input  logic [3:0]                       i_real_reg,
    input  logic [3:0]                       i_entry_caller_index,
    input  logic signed [4:0]                i_entry_callee_index,
    input  rat_pkg::t_cmd                    i_cmd,
    output rat_pkg::t_status                 o_status,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [4:0]                o_reg_result,
    output logic signed [16:0]               o_owner,
    output logic [3:0]                       o_evac_caller_index,
    output logic signed [4:0]                o_evac_callee_index,
    output logic                             o_last
);

    localparam int IW = $clog2(REG_COUNT);
    localparam int XW = (VIRT_WIDTH > 17) ? VIRT_WIDTH : 17;
    localparam int VX = (VIRT_WIDTH > 16) ? VIRT_WIDTH : 16;
    localparam logic [4:0] REG_LIM = 5'(REG_COUNT);

    logic [63:0]            r_caller_order;
    logic [63:0]            r_callee_order;
    logic [4:0]             r_caller_count;
    logic [4:0]             r_callee_count;

    logic [REG_COUNT-1:0]   r_used;
    logic [REG_COUNT-1:0]   n_used;
    logic [VIRT_WIDTH-1:0]  r_id [REG_COUNT];

    logic [3:0]             r_action;
    logic [VIRT_WIDTH-1:0]  r_vid;
    logic [3:0]             r_rr;
    logic                   r_ecei_neg;
    logic [4:0]             r_p;
    logic [4:0]             n_p;
    logic [4:0]             r_q;
    logic [4:0]             n_q;
    logic [4:0]             r_res;
    logic [4:0]             n_res;
    logic [4:0]             r_cur;
    logic [4:0]             n_cur;
    logic                   r_pend_v;
    logic                   n_pend_v;
    logic [3:0]             r_pend_ci;
    logic [3:0]             n_pend_ci;
    logic [4:0]             r_pend_cei;
    logic [4:0]             n_pend_cei;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [4:0]             r_out_reg;
    logic [16:0]            r_out_owner;
    logic [3:0]             r_out_ci;
    logic [4:0]             r_out_cei;
    logic                   r_out_last;

    logic                   emit;
    logic [4:0]             emit_reg;
    logic [16:0]            emit_owner;
    logic [3:0]             emit_ci;
    logic [4:0]             emit_cei;
    logic                   emit_last;

    logic                   id_we;
    logic [IW-1:0]          id_waddr;
    logic [VIRT_WIDTH-1:0]  id_wdata;
    logic [IW-1:0]          rd_addr;
    logic [VIRT_WIDTH-1:0]  rd_id;
    logic [XW-1:0]          rd_id_ext;
    logic [VX-1:0]          vid_ext;

    logic [4:0]             ncaller;
    logic [4:0]             ncallee;
    logic [3:0]             c;
    logic [3:0]             d;
    logic                   c_ok;
    logic                   d_ok;
    logic                   rr_ok;
    logic [IW-1:0]          c_ix;
    logic [IW-1:0]          d_ix;
    logic [IW-1:0]          rr_ix;
    logic [IW-1:0]          p_ix;
    logic                   caller_end;
    logic                   scan_end;
    logic                   out_free;
    logic                   evac_occ;
    logic                   hit;
    logic [4:0]             rec;

    assign ncaller    = (r_caller_count > rat_pkg::LIST_MAX) ? rat_pkg::LIST_MAX
                                                             : r_caller_count;
    assign ncallee    = (r_callee_count > rat_pkg::LIST_MAX) ? rat_pkg::LIST_MAX
                                                             : r_callee_count;
    assign c          = r_caller_order[{r_p[3:0], 2'b00} +: 4];
    assign d          = r_callee_order[{r_q[3:0], 2'b00} +: 4];
    assign c_ok       = {1'b0, c} < REG_LIM;
    assign d_ok       = {1'b0, d} < REG_LIM;
    assign rr_ok      = {1'b0, r_rr} < REG_LIM;
    assign c_ix       = c[IW-1:0];
    assign d_ix       = d[IW-1:0];
    assign rr_ix      = r_rr[IW-1:0];
    assign p_ix       = r_p[IW-1:0];
    assign caller_end = r_p >= ncaller;
    assign scan_end   = r_p >= REG_LIM;
    assign out_free   = !r_out_valid || i_out_ready;
    assign evac_occ   = !caller_end && c_ok && r_used[c_ix];
    assign vid_ext    = VX'(i_virtual_id);

    // single table read port
    always_comb begin
        case (i_cmd.op)
            rat_pkg::DP_SCAN: rd_addr = p_ix;
            rat_pkg::DP_EXEC: rd_addr = d_ix;
            rat_pkg::DP_EMIT: rd_addr = rr_ix;
            default:          rd_addr = c_ix;
        endcase
    end

    assign rd_id     = r_id[rd_addr];
    assign rd_id_ext = XW'(rd_id);

    always_comb begin
        n_used      = r_used;
        n_p         = r_p;
        n_q         = r_q;
        n_res       = r_res;
        n_cur       = r_cur;
        n_pend_v    = r_pend_v;
        n_pend_ci   = r_pend_ci;
        n_pend_cei  = r_pend_cei;
        id_we       = 1'b0;
        id_waddr    = c_ix;
        id_wdata    = r_vid;
        hit         = 1'b0;
        rec         = rat_pkg::REG_NONE;
        emit        = 1'b0;
        emit_reg    = rat_pkg::REG_NONE;
        emit_owner  = rat_pkg::OWNER_NONE;
        emit_ci     = 4'd0;
        emit_cei    = 5'd0;
        emit_last   = 1'b0;
        case (i_cmd.op)
            rat_pkg::DP_ALLOC: begin
                if (!caller_end) begin
                    n_p = r_p + 5'd1;
                    if (c_ok && !r_used[c_ix]) begin
                        n_used[c_ix] = 1'b1;
                        id_we        = 1'b1;
                        n_res        = {1'b0, c};
                        hit          = 1'b1;
                    end
                end
            end
            rat_pkg::DP_FIND: begin
                if (!caller_end) begin
                    n_p = r_p + 5'd1;
                    if (c_ok && r_used[c_ix] && rd_id == r_vid) begin
                        n_cur = {1'b0, c};
                        hit   = 1'b1;
                    end
                end
            end
            rat_pkg::DP_REWIND: begin
                n_p   = 5'd0;
                n_res = r_cur;
            end
            rat_pkg::DP_MOVE: begin
                if (!caller_end) begin
                    n_p = r_p + 5'd1;
                    if (c_ok && {1'b0, c} != r_cur && !r_used[c_ix]) begin
                        n_used[c_ix] = 1'b1;
                        id_we        = 1'b1;
                        if (!r_cur[4]) begin
                            n_used[r_cur[IW-1:0]] = 1'b0;
                        end
                        n_res = {1'b0, c};
                        hit   = 1'b1;
                    end
                end
            end
            rat_pkg::DP_SCAN: begin
                if (!scan_end) begin
                    n_p = r_p + 5'd1;
                    if (r_used[p_ix] && rd_id == r_vid) begin
                        n_res = r_p;
                        hit   = 1'b1;
                        if (r_action == rat_pkg::ACT_FREE) begin
                            n_used[p_ix] = 1'b0;
                        end
                    end
                end
            end
            rat_pkg::DP_EXEC: begin
                case (r_action)
                    rat_pkg::ACT_FORCE: begin
                        if (rr_ok) begin
                            n_used[rr_ix] = 1'b1;
                            id_we         = 1'b1;
                            id_waddr      = rr_ix;
                            n_res         = {1'b0, r_rr};
                        end
                    end
                    rat_pkg::ACT_UNLOCK: begin
                        if (rr_ok) begin
                            n_used[rr_ix] = 1'b0;
                            n_res         = {1'b0, r_rr};
                        end
                    end
                    rat_pkg::ACT_RESTORE: begin
                        if (!r_ecei_neg && r_p < ncaller && r_q < ncallee && c_ok && d_ok) begin
                            n_used[c_ix] = r_used[d_ix];
                            id_we        = 1'b1;
                            id_wdata     = rd_id;
                            n_used[d_ix] = 1'b0;
                            n_res        = {1'b0, c};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rat_pkg::DP_EVAC: begin
                if (!caller_end) begin
                    n_p = r_p + 5'd1;
                end
                if (evac_occ) begin
                    if (r_q < ncallee && d_ok) begin
                        n_used[d_ix] = 1'b1;
                        id_we        = 1'b1;
                        id_waddr     = d_ix;
                        id_wdata     = rd_id;
                        n_used[c_ix] = 1'b0;
                        rec          = r_q;
                    end
                    if (r_pend_v) begin
                        emit     = 1'b1;
                        emit_ci  = r_pend_ci;
                        emit_cei = r_pend_cei;
                    end
                    n_pend_v   = 1'b1;
                    n_pend_ci  = r_p[3:0];
                    n_pend_cei = rec;
                    n_q        = r_q + 5'd1;
                end
            end
            rat_pkg::DP_EMIT_LAST: begin
                emit      = 1'b1;
                emit_ci   = r_pend_ci;
                emit_cei  = r_pend_cei;
                emit_last = 1'b1;
                n_pend_v  = 1'b0;
            end
            rat_pkg::DP_EMIT: begin
                emit = 1'b1;
                if (r_action == rat_pkg::ACT_USEDBY) begin
                    if (rr_ok) begin
                        emit_reg = {1'b0, r_rr};
                        if (r_used[rr_ix]) begin
                            emit_owner = rd_id_ext[16:0];
                        end
                    end
                end else begin
                    emit_reg = r_res;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.load) begin
            n_res    = rat_pkg::REG_NONE;
            n_cur    = rat_pkg::REG_NONE;
            n_pend_v = 1'b0;
            if (i_action == rat_pkg::ACT_RESTORE) begin
                n_p = {1'b0, i_entry_caller_index};
                n_q = {1'b0, i_entry_callee_index[3:0]};
            end else begin
                n_p = 5'd0;
                n_q = 5'd0;
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caller_order <= '0;
            r_caller_count <= '0;
            r_callee_order <= '0;
            r_callee_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rat_pkg::CFG_CALLER_ORDER: r_caller_order <= i_cfg_data;
                rat_pkg::CFG_CALLER_COUNT: r_caller_count <= i_cfg_data[4:0];
                rat_pkg::CFG_CALLEE_ORDER: r_callee_order <= i_cfg_data;
                rat_pkg::CFG_CALLEE_COUNT: r_callee_count <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            r_id[id_waddr] <= id_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_vid      <= vid_ext[VIRT_WIDTH-1:0];
            r_rr       <= i_real_reg;
            r_ecei_neg <= i_entry_callee_index[4];
        end
        r_p        <= n_p;
        r_q        <= n_q;
        r_res      <= n_res;
        r_cur      <= n_cur;
        r_pend_ci  <= n_pend_ci;
        r_pend_cei <= n_pend_cei;
        if (emit) begin
            r_out_reg   <= emit_reg;
            r_out_owner <= emit_owner;
            r_out_ci    <= emit_ci;
            r_out_cei   <= emit_cei;
            r_out_last  <= emit_last;
        end
    end

    assign o_status.caller_end = caller_end;
    assign o_status.scan_end   = scan_end;
    assign o_status.hit        = hit;
    assign o_status.evac_hold  = evac_occ && r_pend_v && !out_free;
    assign o_status.pend_valid = r_pend_v;
    assign o_status.out_free   = out_free;

    assign o_out_valid         = r_out_valid;
    assign o_reg_result        = r_out_reg;
    assign o_owner             = r_out_owner;
    assign o_evac_caller_index = r_out_ci;
    assign o_evac_callee_index = r_out_cei;
    assign o_last              = r_out_last;

endmodule

// ===== sv/register_allocation_table.sv =====
// top level of the register allocation table
//
// i_in carries one action per transfer: allocate, force, realloc, resolve,
// free id, usedby, unlock, evacuate or restore entry. o_out returns one
// result per action, or one record per occupied caller-saved register for
// evacuate (none when nothing is occupied, last set on the final record).
// Order lists and counts are written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only while no action is in
// flight, which the block does not enforce. One action is worked at a
// time; the table walk is one entry per cycle through the single table
// read port. Force, unlock and restore run the execute state; usedby and
// unknown codes go straight to the result; allocate and evacuate walk up
// to caller_count list entries, resolve and free id up to REG_COUNT table
// entries; realloc walks to find the id, rewinds and walks again to move
// it. The input is ready again in the cycle the result shows on o_out.
// Reset frees every table entry, clears the order lists and counts, and
// empties the result register. A stalled receiver holds the result in the
// output register; the walk pauses only when a further result is due.
module register_allocation_table #(
    parameter int REG_COUNT  = 16,
    parameter int VIRT_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rat_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rat_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rat_in_if.sink                           i_in,
    rat_out_if.source                        o_out
);

    rat_pkg::t_cmd    cmd;
    rat_pkg::t_status status;

    rat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rat_datapath #(
        .REG_COUNT  (REG_COUNT),
        .VIRT_WIDTH (VIRT_WIDTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_action             (i_in.action),
        .i_virtual_id         (i_in.virtual_id),
        .i_real_reg           (i_in.real_reg),
        .i_entry_caller_index (i_in.entry_caller_index),
        .i_entry_callee_index (i_in.entry_callee_index),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_out_ready          (o_out.ready),
        .o_out_valid          (o_out.valid),
        .o_reg_result         (o_out.reg_result),
        .o_owner              (o_out.owner),
        .o_evac_caller_index  (o_out.evac_caller_index),
        .o_evac_callee_index  (o_out.evac_callee_index),
        .o_last               (o_out.last)
    );

endmodule

// ===== sv/rat_checker.sv =====
// port-level checks of the register allocation table and their binding
module rat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_reg_result,
    input logic [16:0] i_owner,
    input logic [4:0]  i_evac_callee_index,
    input logic        i_last
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one action at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an action is in flight");

    // an owner is only reported by usedby on a real register
    a_owner_usedby: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_owner != rat_pkg::OWNER_NONE |->
            !i_reg_result[4] && i_evac_callee_index == 5'd0 && !i_last)
        else $error("owner reported outside usedby");

    // the final evacuate record carries no register and no owner
    a_last_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |->
            i_reg_result == rat_pkg::REG_NONE && i_owner == rat_pkg::OWNER_NONE)
        else $error("final evacuate record malformed");

endmodule

bind register_allocation_table rat_checker u_rat_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_reg_result        (o_out.reg_result),
    .i_owner             (o_out.owner),
    .i_evac_callee_index (o_out.evac_callee_index),
    .i_last              (o_out.last)
);
